/* hdl/ffpa_pkg.sv */
// Shared constants, header layout and controller/datapath command and status types.
package ffpa_pkg;

  // Pool geometry: header slots are 8-byte aligned.
  localparam int unsigned POOL_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned HDR_STEP     = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int unsigned POOL_LEN     = (POOL_BYTES / 8) * 8;
  localparam int unsigned DEPTH        = POOL_LEN / 8;
  localparam int unsigned IDX_W        = $clog2(DEPTH);

  // Field widths.
  localparam int unsigned REQ_W   = 20;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned NEED_W  = REQ_W + 1;
  localparam int unsigned SIZE_W  = $clog2(POOL_LEN + 1);
  localparam int unsigned OFF_W   = SIZE_W + 1;
  localparam int unsigned SUM_W   = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
  localparam int unsigned ENTRY_W = SIZE_W + 1;

  // One block header as stored in the header memory.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Which header write the datapath performs.
  typedef enum logic [2:0] {
    WR_INIT  = 3'd0,
    WR_TAKE  = 3'd1,
    WR_SPLIT = 3'd2,
    WR_MARK  = 3'd3,
    WR_MERGE = 3'd4
  } wr_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic     in_ready;
    logic     rd_en;
    logic     rd_next;
    logic     wr_en;
    wr_kind_t wr_kind;
    logic     advance;
    logic     latch_sz;
    logic     res_set;
    logic     res_grant;
    logic     res_addr;
    logic     out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_fire;
    logic in_free;
    logic off_fits;
    logic fit;
    logic split_ok;
    logic fa_null;
    logic fa_ok;
    logic next_fits;
    logic next_free;
    logic out_stall;
  } sts_t;

endpackage

/* hdl/ffpa_if.sv */
// Request and response channel interfaces of the pool allocator.
interface ffpa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ffpa_pkg::REQ_W-1:0]  req_size;
  logic [ffpa_pkg::ADDR_W-1:0] free_address;

  modport source (output valid, action, req_size, free_address, input ready);
  modport sink (input valid, action, req_size, free_address, output ready);
endinterface

interface ffpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [ffpa_pkg::ADDR_W-1:0] payload_address;

  modport source (output valid, granted, payload_address, input ready);
  modport sink (input valid, granted, payload_address, output ready);
endinterface

/* hdl/ffpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ffpa_ctrl.sv */
// Sequencing state machine for the allocate walk and the free/merge steps.
module ffpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  ffpa_pkg::sts_t sts,
  output ffpa_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_A_RD  = 9'b000000100,
    S_A_CHK = 9'b000001000,
    S_A_SPL = 9'b000010000,
    S_F_DEC = 9'b000100000,
    S_F_CHK = 9'b001000000,
    S_F_MRG = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.wr_kind   = ffpa_pkg::WR_INIT;
    case (state)
      S_INIT: begin
        // Seed the pool as one free block.
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = ffpa_pkg::WR_INIT;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          state_next = sts.in_free ? S_F_DEC : S_A_RD;
        end
      end
      S_A_RD: begin
        if (sts.off_fits) begin
          cmd.rd_en  = 1'b1;
          state_next = S_A_CHK;
        end else begin
          cmd.res_set = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_A_CHK: begin
        cmd.latch_sz = 1'b1;
        if (sts.fit) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_kind   = ffpa_pkg::WR_TAKE;
          cmd.res_set   = 1'b1;
          cmd.res_grant = 1'b1;
          cmd.res_addr  = 1'b1;
          state_next    = sts.split_ok ? S_A_SPL : S_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_A_RD;
        end
      end
      S_A_SPL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = ffpa_pkg::WR_SPLIT;
        state_next  = S_FIN;
      end
      S_F_DEC: begin
        if (sts.fa_null) begin
          cmd.res_set   = 1'b1;
          cmd.res_grant = 1'b1;
          state_next    = S_FIN;
        end else if (!sts.fa_ok) begin
          cmd.res_set = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_kind   = ffpa_pkg::WR_MARK;
        cmd.latch_sz  = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_grant = 1'b1;
        if (sts.next_fits) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_F_MRG;
        end else begin
          state_next = S_FIN;
        end
      end
      S_F_MRG: begin
        if (sts.next_free) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_kind = ffpa_pkg::WR_MERGE;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // Check and merge states must see the read issued in the cycle before; a split follows a check.
  a_alloc_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_CHK) |-> $past(cmd.rd_en))
    else $error("allocate check without a prior header read");

  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPL) |-> $past(state == S_A_CHK))
    else $error("split write not preceded by a fitting check");

  a_merge_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_MRG) |-> $past(cmd.rd_en && cmd.rd_next))
    else $error("merge step without a read of the following header");

endmodule

/* hdl/ffpa_dp.sv */
// Datapath: request registers, walk offset, header memory and result register.
module ffpa_dp (
  input  logic           clk,
  input  logic           rst,
  ffpa_req_if.sink       req,
  ffpa_rsp_if.source     rsp,
  input  ffpa_pkg::cmd_t cmd,
  output ffpa_pkg::sts_t sts
);

  localparam int unsigned OW = ffpa_pkg::OFF_W;
  localparam int unsigned SW = ffpa_pkg::SUM_W;
  localparam int unsigned NW = ffpa_pkg::NEED_W;
  localparam int unsigned ZW = ffpa_pkg::SIZE_W;
  localparam int unsigned IW = ffpa_pkg::IDX_W;
  localparam int unsigned AW = ffpa_pkg::ADDR_W;

  // Request state.
  logic [NW-1:0] need_q;
  logic [AW-1:0] fa_q;
  logic [OW-1:0] off_q;
  logic [ZW-1:0] sz_q;
  logic          res_granted;
  logic [AW-1:0] res_addr;
  logic          out_valid;
  logic          out_granted;
  logic [AW-1:0] out_addr;

  // Memory ports.
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  ffpa_pkg::entry_t            ram_wdata;
  logic [ffpa_pkg::ENTRY_W-1:0] ram_rdata;
  logic [IW-1:0]               ram_raddr;
  ffpa_pkg::entry_t            rd_ent;

  logic          in_fire;
  logic [NW-1:0] need_n;
  logic [SW-1:0] split_off;
  logic [SW-1:0] step_off;
  logic [SW-1:0] merged;
  logic [ZW-1:0] merge_size;
  logic [ZW-1:0] rest_size;
  logic [OW-1:0] grant_off;

  assign in_fire   = req.valid && req.ready;
  assign req.ready = cmd.in_ready;
  assign rd_ent    = ffpa_pkg::entry_t'(ram_rdata);
  assign need_n    = NW'(req.req_size) + NW'(7);

  // Offsets derived from the current block and the header just read.
  assign split_off = SW'(off_q) + SW'(ffpa_pkg::HDR_STEP) + SW'(need_q);
  assign step_off  = SW'(off_q) + SW'(ffpa_pkg::HDR_STEP) + SW'(rd_ent.size);
  assign merged    = SW'(sz_q) + SW'(ffpa_pkg::HDR_STEP) + SW'(rd_ent.size);
  assign merge_size = (merged > SW'(ffpa_pkg::POOL_LEN)) ? ZW'(ffpa_pkg::POOL_LEN)
                                                        : merged[ZW-1:0];
  assign rest_size = ZW'(SW'(sz_q) - SW'(need_q) - SW'(ffpa_pkg::HDR_STEP));
  assign grant_off = off_q + OW'(ffpa_pkg::HDR_STEP);

  // Status toward the controller.
  always_comb begin
    sts.in_fire   = in_fire;
    sts.in_free   = req.action;
    sts.off_fits  = off_q <= OW'(ffpa_pkg::POOL_LEN - ffpa_pkg::HDR_STEP);
    sts.fit       = rd_ent.free && (SW'(rd_ent.size) >= SW'(need_q));
    sts.split_ok  = (SW'(rd_ent.size) > SW'(need_q) + SW'(ffpa_pkg::HDR_STEP)) &&
                    (split_off < SW'(ffpa_pkg::POOL_LEN));
    sts.fa_null   = fa_q == '0;
    sts.fa_ok     = (OW'(fa_q) >= OW'(ffpa_pkg::HDR_STEP)) && (fa_q[2:0] == 3'b000) &&
                    (OW'(fa_q) <= OW'(ffpa_pkg::POOL_LEN));
    sts.next_fits = step_off <= SW'(ffpa_pkg::POOL_LEN - ffpa_pkg::HDR_STEP);
    sts.next_free = rd_ent.free;
    sts.out_stall = out_valid && !rsp.ready;
  end

  // Read address: current block, or the block that follows the one just read.
  assign ram_raddr = cmd.rd_next ? step_off[IW+2:3] : off_q[IW+2:3];

  // Header write selection.
  always_comb begin
    ram_we    = cmd.wr_en;
    ram_waddr = off_q[IW+2:3];
    ram_wdata = rd_ent;
    case (cmd.wr_kind)
      ffpa_pkg::WR_INIT: begin
        ram_waddr      = '0;
        ram_wdata.free = 1'b1;
        ram_wdata.size = ZW'(ffpa_pkg::POOL_LEN - ffpa_pkg::HDR_STEP);
      end
      ffpa_pkg::WR_TAKE: begin
        ram_wdata.free = 1'b0;
        ram_wdata.size = sts.split_ok ? ZW'(need_q) : rd_ent.size;
      end
      ffpa_pkg::WR_SPLIT: begin
        ram_waddr      = split_off[IW+2:3];
        ram_wdata.free = 1'b1;
        ram_wdata.size = rest_size;
      end
      ffpa_pkg::WR_MARK: begin
        ram_wdata.free = 1'b1;
        ram_wdata.size = rd_ent.size;
      end
      ffpa_pkg::WR_MERGE: begin
        ram_wdata.free = 1'b1;
        ram_wdata.size = merge_size;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffpa_ram #(
    .WIDTH (ffpa_pkg::ENTRY_W),
    .DEPTH (ffpa_pkg::DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request capture, walk offset and pending result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      need_q <= {need_n[NW-1:3], 3'b000};
      fa_q   <= req.free_address;
      off_q  <= req.action ? (OW'(req.free_address) - OW'(ffpa_pkg::HDR_STEP)) : '0;
    end else if (cmd.advance) begin
      off_q <= step_off[OW-1:0];
    end
    if (cmd.latch_sz) begin
      sz_q <= rd_ent.size;
    end
    if (cmd.res_set) begin
      res_granted <= cmd.res_grant;
      res_addr    <= cmd.res_addr ? grant_off[AW-1:0] : '0;
    end
  end

  // Output register: holds a finished transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_granted <= res_granted;
      out_addr    <= res_addr;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.granted         = out_granted;
  assign rsp.payload_address = out_addr;

  // A header write never targets the slot being read in the same cycle.
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && ram_we) |-> (ram_raddr != ram_waddr))
    else $error("header read and write to the same slot");

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a load");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_addr == '0))
    else $error("failed transaction carries a nonzero address");

endmodule

/* hdl/first_fit_pool_allocator.sv */
// Top level of the first-fit pool allocator: controller, datapath and channels.
//
//   Channel | Direction | Payload                               | Handshake
//   req     | in        | action, req_size, free_address        | valid/ready
//   rsp     | out       | granted, payload_address              | valid/ready
//
// Allocate: the walk reads and checks one header per block visited until a fit, and a split
// adds a write of the remainder header; a walk with no fit ends when the offset leaves the pool.
// Free: a null or invalid address is answered at decode; else its header is read, then the next.
// After reset the pool header is seeded first; req.ready rises after it.
// A transaction is taken only while the block is idle; a stalled rsp holds the
// result register, and a finished transaction waits for it to empty.
module first_fit_pool_allocator (
  input logic        clk,
  input logic        rst,
  ffpa_req_if.sink   req,
  ffpa_rsp_if.source rsp
);

  ffpa_pkg::cmd_t cmd;
  ffpa_pkg::sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ffpa_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

/* tb/first_fit_pool_allocator_tb.sv */
// Self-checking testbench for the first-fit pool allocator.
module first_fit_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Local aliases of the shared geometry and field widths.
  localparam int unsigned AW       = ffpa_pkg::ADDR_W;
  localparam int unsigned RW       = ffpa_pkg::REQ_W;
  localparam int unsigned ZW       = ffpa_pkg::SIZE_W;
  localparam int unsigned DEPTH    = ffpa_pkg::DEPTH;
  localparam int unsigned POOL_LEN = ffpa_pkg::POOL_LEN;
  localparam int unsigned HDR_STEP = ffpa_pkg::HDR_STEP;

  // Request codes carried by the action field.
  localparam bit ACT_ALLOC = 1'b0;
  localparam bit ACT_FREE  = 1'b1;

  // Cycles the receiver holds off when asked for a long stall.
  localparam int LONG_HOLD = 400;

  // One expected response.
  typedef struct packed {
    logic          granted;
    logic [AW-1:0] addr;
  } grant_t;

  // Keeps a private copy of the header store, predicts every response and checks it.
  class pool_scoreboard;
    logic [ZW-1:0] blk_size [DEPTH];
    bit            blk_free [DEPTH];
    bit            blk_seen [DEPTH];
    grant_t        grants_due [$];
    logic [AW-1:0] live_blocks [$];
    logic [AW-1:0] chain_list [$];
    int            mismatches;
    int            n_alloc_ok, n_alloc_fail, n_free_done, n_free_null, n_free_bad;
    int            n_checked;

    function new();
      foreach (blk_size[i]) begin
        blk_size[i] = '0;
        blk_free[i] = 1'b0;
        blk_seen[i] = 1'b0;
      end
      // The pool starts as one free block spanning everything.
      blk_size[0] = ZW'(POOL_LEN - HDR_STEP);
      blk_free[0] = 1'b1;
      blk_seen[0] = 1'b1;
    endfunction

    // True when a whole header at byte offset off lies inside the pool.
    function bit hdr_fits(int unsigned off);
      return off < POOL_LEN && POOL_LEN - off >= HDR_STEP;
    endfunction

    // A free is safe to issue when it reads no header that was never written.
    function bit free_ok(logic [AW-1:0] fa);
      int unsigned a, off, nxt;
      a = 32'(fa);
      if (a < HDR_STEP || a % 8 != 0 || !hdr_fits(a - HDR_STEP)) return 1'b1;
      off = a - HDR_STEP;
      if (!blk_seen[off / 8]) return 1'b0;
      nxt = off + HDR_STEP + 32'(blk_size[off / 8]);
      return !hdr_fits(nxt) || blk_seen[nxt / 8];
    endfunction

    // Any written header whose free is safe, searched from a random slot.
    function logic [AW-1:0] written_header_target();
      int unsigned start, idx, a;
      start = $urandom_range(0, DEPTH - 1);
      for (int unsigned k = 0; k < DEPTH; k++) begin
        idx = (start + k) % DEPTH;
        a = idx * 8 + HDR_STEP;
        if (blk_seen[idx] && a <= 32'hFFFF && free_ok(AW'(a))) return AW'(a);
      end
      return '0;
    endfunction

    // Payload addresses of every block reachable by walking from offset 0.
    function void list_chain();
      int unsigned off;
      chain_list.delete();
      off = 0;
      while (hdr_fits(off)) begin
        if (off + HDR_STEP <= 32'hFFFF) chain_list.push_back(AW'(off + HDR_STEP));
        off = off + HDR_STEP + 32'(blk_size[off / 8]);
      end
    endfunction

    function void drop_live(logic [AW-1:0] a);
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == a) begin
          live_blocks.delete(i);
          return;
        end
      end
    endfunction

    // Apply one accepted request to the header store and queue its response.
    function void note_request(bit act, logic [RW-1:0] size, logic [AW-1:0] fa);
      grant_t      g;
      int unsigned need, off, idx, sz, noff, a, merged;
      g.granted = 1'b0;
      g.addr = '0;
      if (act == ACT_ALLOC) begin
        // First fit: walk the headers from offset 0.
        need = (32'(size) + 32'd7) & ~32'd7;
        off = 0;
        while (hdr_fits(off)) begin
          idx = off / 8;
          sz = 32'(blk_size[idx]);
          if (blk_free[idx] && sz >= need) begin
            blk_free[idx] = 1'b0;
            if (sz > need + HDR_STEP) begin
              noff = off + HDR_STEP + need;
              if (noff / 8 < DEPTH) begin
                blk_size[noff / 8] = ZW'(sz - need - HDR_STEP);
                blk_free[noff / 8] = 1'b1;
                blk_seen[noff / 8] = 1'b1;
                blk_size[idx] = ZW'(need);
              end
            end
            g.granted = 1'b1;
            g.addr = AW'(off + HDR_STEP);
            if (g.addr != 0) live_blocks.push_back(g.addr);
            break;
          end
          off = off + HDR_STEP + sz;
        end
        if (g.granted) n_alloc_ok++;
        else n_alloc_fail++;
      end else begin
        a = 32'(fa);
        if (a == 0) begin
          g.granted = 1'b1;
          n_free_null++;
        end else if (a >= HDR_STEP && a % 8 == 0 && hdr_fits(a - HDR_STEP)) begin
          // Mark free, then merge with the following block only.
          off = a - HDR_STEP;
          idx = off / 8;
          sz = 32'(blk_size[idx]);
          noff = off + HDR_STEP + sz;
          blk_free[idx] = 1'b1;
          if (hdr_fits(noff) && blk_free[noff / 8]) begin
            merged = sz + HDR_STEP + 32'(blk_size[noff / 8]);
            if (merged > POOL_LEN) merged = POOL_LEN;
            blk_size[idx] = ZW'(merged);
          end
          g.granted = 1'b1;
          drop_live(fa);
          n_free_done++;
        end else begin
          n_free_bad++;
        end
      end
      grants_due.push_back(g);
    endfunction

    function int pending();
      return grants_due.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compare one accepted response with the oldest expectation.
    task check_grant(logic granted, logic [AW-1:0] addr);
      grant_t g;
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("unexpected response granted=%0b addr=%0d",
                                  granted, addr));
        return;
      end
      g = grants_due.pop_front();
      n_checked++;
      if (granted !== g.granted)
        report_mismatch($sformatf("response %0d granted=%0b, want %0b",
                                  n_checked, granted, g.granted));
      if (addr !== g.addr)
        report_mismatch($sformatf("response %0d payload_address=%0d, want %0d",
                                  n_checked, addr, g.addr));
    endtask

    task close_out();
      if (grants_due.size() != 0)
        report_mismatch($sformatf("%0d expected responses never arrived",
                                  grants_due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  ffpa_req_if req ();
  ffpa_rsp_if rsp ();

  first_fit_pool_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pool_scoreboard sb = new();

  int items_sent = 0;
  int hold_asks = 0;
  int long_holds = 0;
  bit rsp_calm = 1'b0;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random idle length: mostly short, sometimes long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request sizes: mostly small, a few far beyond the pool.
  function automatic logic [RW-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return RW'($urandom_range(0, 256));
    if (r < 85) return RW'($urandom_range(257, 4096));
    if (r < 95) return RW'($urandom_range(4097, 20000));
    return RW'($urandom_range(20001, 20'hFFFFF));
  endfunction

  // Free targets: mostly live blocks, plus null, invalid and stale headers.
  function automatic logic [AW-1:0] pick_free_target();
    int            r;
    logic [AW-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) begin
      a = AW'($urandom);
      if (a[2:0] == 3'd0) a[0] = 1'b1;
      return a;
    end
    if (r < 14) return AW'($urandom_range(1, 2) * 8);
    if (r < 22) begin
      a = sb.written_header_target();
      if (a != 0) return a;
    end
    return sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_request(bit act, logic [RW-1:0] size, logic [AW-1:0] fa);
    if (act == ACT_FREE && !sb.free_ok(fa)) fa = '0;
    req.valid <= 1'b1;
    req.action <= act;
    req.req_size <= size;
    req.free_address <= fa;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(act, size, fa);
    items_sent++;
  endtask

  task automatic pause_sender(int n);
    if (n == 0) return;
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering until every expected response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_request(bit calm);
    int            r;
    bit            act;
    logic [RW-1:0] size;
    logic [AW-1:0] fa;
    r = $urandom_range(0, 99);
    size = pick_size();
    fa = AW'($urandom);
    act = ACT_FREE;
    if (sb.live_blocks.size() < 4 || (r < 52 && sb.live_blocks.size() < 48)) act = ACT_ALLOC;
    if (act == ACT_FREE) fa = pick_free_target();
    send_request(act, size, fa);
    if (!calm && $urandom_range(0, 99) < 35) pause_sender(gap_cycles());
  endtask

  // Free every block on the chain from the top down, which folds the pool back together.
  task automatic sweep_pool(bit calm);
    sb.list_chain();
    for (int i = sb.chain_list.size() - 1; i >= 0; i--) begin
      send_request(ACT_FREE, RW'($urandom), sb.chain_list[i]);
      if (!calm && $urandom_range(0, 99) < 25) pause_sender(gap_cycles());
    end
    sb.live_blocks.delete();
  endtask

  // Request side: reset, directed cases, then random phases.
  initial begin
    bit calm;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.action <= ACT_ALLOC;
    req.req_size <= '0;
    req.free_address <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed cases: extremes, rounding, splits, merges and every kind of free.
    send_request(ACT_ALLOC, 20'd0, AW'($urandom));
    send_request(ACT_ALLOC, 20'd1, AW'($urandom));
    send_request(ACT_ALLOC, 20'hFFFFF, AW'($urandom));
    send_request(ACT_ALLOC, 20'd65512, AW'($urandom));
    send_request(ACT_FREE, RW'($urandom), 16'd0);
    send_request(ACT_FREE, RW'($urandom), 16'hFFFF);
    send_request(ACT_FREE, RW'($urandom), 16'd16);
    send_request(ACT_ALLOC, 20'd30000, AW'($urandom));
    send_request(ACT_ALLOC, 20'd20000, AW'($urandom));
    send_request(ACT_ALLOC, 20'd15000, AW'($urandom));
    // High block freed: it merges with the small remainder behind it.
    send_request(ACT_FREE, RW'($urandom), 16'd50128);
    send_request(ACT_FREE, RW'($urandom), 16'd50128);
    // The remainder's old header is no longer a block and is last in the pool.
    send_request(ACT_FREE, RW'($urandom), 16'd65152);
    send_request(ACT_ALLOC, 20'd15408, AW'($urandom));
    send_request(ACT_ALLOC, 20'd8, AW'($urandom));
    send_request(ACT_FREE, RW'($urandom), 16'd48);
    send_request(ACT_FREE, RW'($urandom), 16'd24);
    send_request(ACT_ALLOC, 20'd20, AW'($urandom));
    send_request(ACT_ALLOC, 20'd9, AW'($urandom));
    wait_drained();
    sweep_pool(1'b1);

    // Random phases, each closed by a full drain and a sweep of the pool.
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      rsp_calm <= (phase == 3);
      if (phase == 1 || phase == 4) hold_asks <= hold_asks + 1;
      repeat (320) random_request(calm);
      wait_drained();
      sweep_pool(calm);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    sb.close_out();
    $display("Sent %0d requests: %0d allocations granted, %0d failed, %0d frees done,",
             items_sent, sb.n_alloc_ok, sb.n_alloc_fail, sb.n_free_done);
    $display("%0d null and %0d invalid frees; %0d responses checked, %0d long receiver holds.",
             sb.n_free_null, sb.n_free_bad, sb.n_checked, long_holds);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Response side: random back-pressure and checking of every accepted transaction.
  initial begin
    int hold;
    int asks_seen;
    hold = 0;
    asks_seen = 0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        sb.check_grant(rsp.granted, rsp.payload_address);
      if (hold > 0) hold--;
      if (hold == 0) begin
        if (hold_asks != asks_seen) begin
          asks_seen = hold_asks;
          hold = LONG_HOLD;
          long_holds++;
        end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
          hold = gap_cycles();
        end
      end
      rsp.ready <= (hold == 0);
      @(posedge clk);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #100_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
